>>> design/soil_enthalpy_mass_shift_update_macros.svh
// assertion helpers shared by the design files
`ifndef SOIL_ENTHALPY_MASS_SHIFT_UPDATE_MACROS_SVH
`define SOIL_ENTHALPY_MASS_SHIFT_UPDATE_MACROS_SVH
`ifndef ASSERT_OFF
`define SEMSU_ASSERT(lbl, ck, rn, prop, msg) \
	lbl: assert property (@(posedge ck) disable iff (!rn) (prop)) else $error(msg);
`define SEMSU_ASSERT_IMP(lbl, ck, rn, pre, post, msg) \
	lbl: assert property (@(posedge ck) disable iff (!rn) (pre) |-> (post)) else $error(msg);
`else
`define SEMSU_ASSERT(lbl, ck, rn, prop, msg)
`define SEMSU_ASSERT_IMP(lbl, ck, rn, pre, post, msg)
`endif
`endif

>>> design/semsu_pkg.sv
package semsu_pkg;
	localparam int FRAC_BITS_DEF  = 16;
	localparam int ENTH_WIDTH_DEF = 48;

	// intermediate values saturate to +-(2^62 - 1)
	localparam logic signed [63:0] LIM = 64'sh3FFF_FFFF_FFFF_FFFF;

	localparam int CFG_IDX_W  = 2;
	localparam int CFG_DATA_W = 47;
	localparam int RATIO_W    = 18;

	localparam logic [CFG_IDX_W-1:0] CFG_LATENT      = 2'd0;
	localparam logic [CFG_IDX_W-1:0] CFG_RATIO_WATER = 2'd1;
	localparam logic [CFG_IDX_W-1:0] CFG_RATIO_ICE   = 2'd2;

	localparam logic [1:0] ST_OK   = 2'd0;
	localparam logic [1:0] ST_ZERO = 2'd1;
	localparam logic [1:0] ST_SAT  = 2'd2;
endpackage

>>> design/semsu_mul.sv
`include "soil_enthalpy_mass_shift_update_macros.svh"

module semsu_mul #(
	parameter int FRAC_BITS = semsu_pkg::FRAC_BITS_DEF,
	parameter int LANES     = 1,
	parameter int SIDE_W    = 1
) (
	input  logic                     clk,
	input  logic                     arst_n,
	input  logic                     en,
	input  logic                     in_valid,
	input  logic signed [63:0]       a [LANES],
	input  logic signed [63:0]       b [LANES],
	input  logic        [SIDE_W-1:0] in_side,
	output logic                     out_valid,
	output logic signed [63:0]       p [LANES],
	output logic                     sat [LANES],
	output logic        [SIDE_W-1:0] out_side
);
	import semsu_pkg::*;

	logic               vld_s1, vld_s2, vld_s3;
	logic [SIDE_W-1:0]  side_s1, side_s2, side_s3;
	logic [63:0]        ma_s1 [LANES];
	logic [63:0]        mb_s1 [LANES];
	logic               neg_s1 [LANES];
	logic [63:0]        p00_s2 [LANES];
	logic [63:0]        p01_s2 [LANES];
	logic [63:0]        p10_s2 [LANES];
	logic [63:0]        p11_s2 [LANES];
	logic               neg_s2 [LANES];
	logic [127:0]       prod_s3 [LANES];
	logic               neg_s3 [LANES];
	logic               sat_c [LANES];
	logic [63:0]        mag_c [LANES];

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			vld_s1    <= 1'b0;
			vld_s2    <= 1'b0;
			vld_s3    <= 1'b0;
			out_valid <= 1'b0;
		end else if (en) begin
			vld_s1    <= in_valid;
			vld_s2    <= vld_s1;
			vld_s3    <= vld_s2;
			out_valid <= vld_s3;
		end
	end

	// product above the cap: any bit at or over 2^62 after the shift
	always_comb begin
		for (int l = 0; l < LANES; l++) begin
			sat_c[l] = |prod_s3[l][127:62+FRAC_BITS];
			mag_c[l] = sat_c[l] ? LIM : {2'b00, prod_s3[l][61+FRAC_BITS:FRAC_BITS]};
		end
	end

	always_ff @(posedge clk) begin
		if (en) begin
			side_s1  <= in_side;
			side_s2  <= side_s1;
			side_s3  <= side_s2;
			out_side <= side_s3;
			for (int l = 0; l < LANES; l++) begin
				ma_s1[l]   <= a[l][63] ? 64'(-a[l]) : 64'(a[l]);
				mb_s1[l]   <= b[l][63] ? 64'(-b[l]) : 64'(b[l]);
				neg_s1[l]  <= a[l][63] ^ b[l][63];
				p00_s2[l]  <= 64'(ma_s1[l][31:0]) * 64'(mb_s1[l][31:0]);
				p01_s2[l]  <= 64'(ma_s1[l][31:0]) * 64'(mb_s1[l][63:32]);
				p10_s2[l]  <= 64'(ma_s1[l][63:32]) * 64'(mb_s1[l][31:0]);
				p11_s2[l]  <= 64'(ma_s1[l][63:32]) * 64'(mb_s1[l][63:32]);
				neg_s2[l]  <= neg_s1[l];
				prod_s3[l] <= {p11_s2[l], p00_s2[l]} + ({64'b0, p01_s2[l]} << 32)
					+ ({64'b0, p10_s2[l]} << 32);
				neg_s3[l]  <= neg_s2[l];
				p[l]       <= neg_s3[l] ? -$signed(mag_c[l]) : $signed(mag_c[l]);
				sat[l]     <= sat_c[l];
			end
		end
	end

	`SEMSU_ASSERT_IMP(a_mul_sat_cap, clk, arst_n, out_valid && sat[0], p[0] == LIM || p[0] == -LIM, "multiplier saturation without capped product")
endmodule

>>> design/semsu_div.sv
`include "soil_enthalpy_mass_shift_update_macros.svh"

module semsu_div #(
	parameter int FRAC_BITS = semsu_pkg::FRAC_BITS_DEF,
	parameter int LANES     = 1,
	parameter int SIDE_W    = 1
) (
	input  logic                     clk,
	input  logic                     arst_n,
	input  logic                     en,
	input  logic                     in_valid,
	input  logic signed [63:0]       num [LANES],
	input  logic signed [63:0]       den [LANES],
	input  logic        [SIDE_W-1:0] in_side,
	output logic                     out_valid,
	output logic signed [63:0]       quo [LANES],
	output logic                     sat [LANES],
	output logic                     zero [LANES],
	output logic        [SIDE_W-1:0] out_side
);
	import semsu_pkg::*;

	// one restoring step per stage, dividend shifted left by FRAC_BITS
	localparam int STEPS = 64 + FRAC_BITS;

	typedef struct packed {
		logic [63:0] rem;
		logic [63:0] quo;
		logic [63:0] num;
		logic [63:0] dvs;
		logic        neg;
		logic        zero;
		logic        sat;
	} lane_t;

	lane_t             lane_s [STEPS+1][LANES];
	logic              vld_s [STEPS+1];
	logic [SIDE_W-1:0] side_s [STEPS+1];
	logic [63:0]       mag_c [LANES];

	function automatic lane_t div_step(input lane_t x, input logic bit_in);
		lane_t       y;
		logic [63:0] r;
		y = x;
		// quotient past 2^61 before the shift would overrun the cap
		y.sat = x.sat | (|x.quo[63:61]);
		r = {x.rem[62:0], bit_in};
		y.quo = {x.quo[62:0], 1'b0};
		if (r >= x.dvs) begin
			r = r - x.dvs;
			y.quo[0] = 1'b1;
		end
		y.rem = r;
		return y;
	endfunction

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			for (int k = 0; k <= STEPS; k++) vld_s[k] <= 1'b0;
			out_valid <= 1'b0;
		end else if (en) begin
			vld_s[0] <= in_valid;
			for (int k = 0; k < STEPS; k++) vld_s[k+1] <= vld_s[k];
			out_valid <= vld_s[STEPS];
		end
	end

	always_ff @(posedge clk) begin
		if (en) begin
			side_s[0] <= in_side;
			for (int k = 0; k < STEPS; k++) side_s[k+1] <= side_s[k];
			out_side <= side_s[STEPS];
		end
	end

	for (genvar l = 0; l < LANES; l++) begin : g_entry
		always_ff @(posedge clk) begin
			if (en) begin
				lane_s[0][l].rem  <= '0;
				lane_s[0][l].quo  <= '0;
				lane_s[0][l].num  <= num[l][63] ? 64'(-num[l]) : 64'(num[l]);
				lane_s[0][l].dvs  <= den[l][63] ? 64'(-den[l]) : 64'(den[l]);
				lane_s[0][l].neg  <= num[l][63] ^ den[l][63];
				lane_s[0][l].zero <= (den[l] == 64'sd0);
				lane_s[0][l].sat  <= 1'b0;
			end
		end
	end

	for (genvar k = 0; k < STEPS; k++) begin : g_step
		localparam int BITPOS = STEPS - 1 - k - FRAC_BITS;
		for (genvar l = 0; l < LANES; l++) begin : g_lane
			logic bit_in;
			if (BITPOS >= 0) begin : g_num
				assign bit_in = lane_s[k][l].num[BITPOS];
			end else begin : g_pad
				assign bit_in = 1'b0;
			end
			always_ff @(posedge clk) begin
				if (en) lane_s[k+1][l] <= div_step(lane_s[k][l], bit_in);
			end
		end
	end

	always_comb begin
		for (int l = 0; l < LANES; l++) begin
			if (lane_s[STEPS][l].zero) mag_c[l] = '0;
			else if (lane_s[STEPS][l].sat) mag_c[l] = LIM;
			else mag_c[l] = lane_s[STEPS][l].quo;
		end
	end

	always_ff @(posedge clk) begin
		if (en) begin
			for (int l = 0; l < LANES; l++) begin
				quo[l]  <= lane_s[STEPS][l].neg ? -$signed(mag_c[l]) : $signed(mag_c[l]);
				sat[l]  <= lane_s[STEPS][l].sat & ~lane_s[STEPS][l].zero;
				zero[l] <= lane_s[STEPS][l].zero;
			end
		end
	end

	`SEMSU_ASSERT_IMP(a_div_zero_clears, clk, arst_n, out_valid && zero[0], quo[0] == 64'sd0 && !sat[0], "zero divisor left a nonzero quotient")
	`SEMSU_ASSERT_IMP(a_div_sat_cap, clk, arst_n, out_valid && sat[0], quo[0] == LIM || quo[0] == -LIM, "divider saturation without capped quotient")
endmodule

>>> design/soil_enthalpy_mass_shift_update.sv
// channel  | handshake                    | payload
// ---------+------------------------------+------------------------------------------
// in       | in_valid / in_ready          | enthalpy, water_ice_content, solid_content,
//          |                              | water_change, solid_change, layer_depth
// out      | out_valid / out_ready        | new_enthalpy, status
// cfg      | cfg_wen (no wait)            | cfg_index, cfg_wdata
//
// one gridpoint per cycle when not stalled; the pipeline is built around four chained
// dividers of one restoring step per stage
// the whole pipeline advances together; it stalls only while a result waits in the
// output register, and in_ready follows that
// reset clears valid bits and configuration registers, no clearing pass
`include "soil_enthalpy_mass_shift_update_macros.svh"

module soil_enthalpy_mass_shift_update #(
	parameter int FRAC_BITS  = semsu_pkg::FRAC_BITS_DEF,
	parameter int ENTH_WIDTH = semsu_pkg::ENTH_WIDTH_DEF
) (
	input  logic                                clk,
	input  logic                                arst_n,
	input  logic                                cfg_wen,
	input  logic [semsu_pkg::CFG_IDX_W-1:0]     cfg_index,
	input  logic [semsu_pkg::CFG_DATA_W-1:0]    cfg_wdata,
	input  logic                                in_valid,
	output logic                                in_ready,
	input  logic signed [ENTH_WIDTH-1:0]        enthalpy,
	input  logic        [31:0]                  water_ice_content,
	input  logic        [31:0]                  solid_content,
	input  logic signed [31:0]                  water_change,
	input  logic signed [31:0]                  solid_change,
	input  logic        [31:0]                  layer_depth,
	output logic                                out_valid,
	input  logic                                out_ready,
	output logic signed [ENTH_WIDTH-1:0]        new_enthalpy,
	output logic        [1:0]                   status
);
	import semsu_pkg::*;

	localparam logic [1:0] BR_THAW   = 2'd0;
	localparam logic [1:0] BR_FREEZE = 2'd1;
	localparam logic [1:0] BR_PHASE  = 2'd2;

	localparam logic signed [65:0] EMAX = (66'sd1 <<< (ENTH_WIDTH - 1)) - 66'sd1;
	localparam logic signed [65:0] EMIN = -EMAX - 66'sd1;

	typedef struct packed {
		logic sat;
		logic zero;
	} flags_t;

	typedef struct packed {
		logic signed [63:0] e;
		logic signed [31:0] wc;
		logic signed [31:0] sc;
		logic        [31:0] dep;
	} base_t;

	typedef struct packed {
		base_t              base;
		logic signed [63:0] rw;
		logic signed [63:0] rs;
		flags_t             fl;
	} b_side_t;

	typedef struct packed {
		base_t              base;
		logic signed [63:0] rw;
		logic signed [63:0] rs;
		logic        [1:0]  br;
		flags_t             fl;
	} c_side_t;

	typedef struct packed {
		base_t              base;
		logic signed [63:0] rs;
		logic signed [63:0] ew;
		flags_t             fl;
	} d_side_t;

	typedef struct packed {
		base_t              base;
		logic signed [63:0] ew;
		flags_t             fl;
	} e_side_t;

	typedef struct packed {
		logic signed [63:0] e;
		logic        [31:0] dep;
		flags_t             fl;
	} f_side_t;

	typedef struct packed {
		logic signed [63:0] e;
		flags_t             fl;
	} g_side_t;

	typedef struct packed {
		logic signed [63:0] val;
		logic               sat;
	} isum_t;

	function automatic isum_t iadd(input logic signed [63:0] x, input logic signed [63:0] y);
		logic signed [64:0] s;
		isum_t              r;
		s = 65'(x) + 65'(y);
		if (s > 65'(LIM)) begin
			r.val = LIM;
			r.sat = 1'b1;
		end else if (s < -65'(LIM)) begin
			r.val = -LIM;
			r.sat = 1'b1;
		end else begin
			r.val = s[63:0];
			r.sat = 1'b0;
		end
		return r;
	endfunction

	logic                  en;
	logic [CFG_DATA_W-1:0] lh_q;
	logic [RATIO_W-1:0]    ratio_w_q;
	logic [RATIO_W-1:0]    ratio_i_q;

	// relative contents
	base_t                 a_side;
	logic signed [63:0]    a_num [2];
	logic signed [63:0]    a_den [2];
	logic                  a_vld;
	logic signed [63:0]    qa [2];
	logic                  sata [2];
	logic                  zeroa [2];
	logic [$bits(base_t)-1:0] a_side_o;

	// latent heat and both denominator products
	b_side_t               b_side;
	logic signed [63:0]    b_a [3];
	logic signed [63:0]    b_b [3];
	logic                  b_vld;
	logic signed [63:0]    pb [3];
	logic                  satb [3];
	logic [$bits(b_side_t)-1:0] b_side_o;

	b_side_t               b_sd;
	logic                  b_thaw;
	logic                  b_frozen;
	isum_t                 b_den;
	c_side_t               c_next;

	logic                  c_vld_s3;
	c_side_t               c_side_s3;
	logic signed [63:0]    c_num_s3 [1];
	logic signed [63:0]    c_den_s3 [1];

	logic                  c_vld;
	logic signed [63:0]    qc [1];
	logic                  satc [1];
	logic                  zeroc [1];
	logic [$bits(c_side_t)-1:0] c_side_o;

	c_side_t               c_sd;
	isum_t                 c_lh;
	d_side_t               d_next;

	logic                  d_vld_s5;
	d_side_t               d_side_s5;
	logic signed [63:0]    d_a_s5 [1];
	logic signed [63:0]    d_b_s5 [1];

	logic                  d_vld;
	logic signed [63:0]    pd [1];
	logic                  satd [1];
	logic [$bits(d_side_t)-1:0] d_side_o;

	d_side_t               d_sd;
	isum_t                 d_t;
	e_side_t               e_next;

	logic                  e_vld_s7;
	e_side_t               e_side_s7;
	logic signed [63:0]    e_num_s7 [1];
	logic signed [63:0]    e_den_s7 [1];

	logic                  e_vld;
	logic signed [63:0]    qe [1];
	logic                  sate [1];
	logic                  zeroe [1];
	logic [$bits(e_side_t)-1:0] e_side_o;

	e_side_t               e_sd;
	f_side_t               f_side;
	logic signed [63:0]    f_a [2];
	logic signed [63:0]    f_b [2];
	logic                  f_vld;
	logic signed [63:0]    pf [2];
	logic                  satf [2];
	logic [$bits(f_side_t)-1:0] f_side_o;

	f_side_t               f_sd;
	g_side_t               g_side;
	logic signed [63:0]    g_den [2];
	logic                  g_vld;
	logic signed [63:0]    qg [2];
	logic                  satg [2];
	logic                  zerog [2];
	logic [$bits(g_side_t)-1:0] g_side_o;

	g_side_t               g_sd;
	logic signed [65:0]    tot;
	logic signed [65:0]    res;
	logic                  res_sat;
	flags_t                fin;

	assign en       = ~out_valid | out_ready;
	assign in_ready = en;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			lh_q      <= '0;
			ratio_w_q <= '0;
			ratio_i_q <= '0;
		end else if (cfg_wen) begin
			unique case (cfg_index)
				CFG_LATENT:      lh_q      <= cfg_wdata;
				CFG_RATIO_WATER: ratio_w_q <= cfg_wdata[RATIO_W-1:0];
				CFG_RATIO_ICE:   ratio_i_q <= cfg_wdata[RATIO_W-1:0];
				default: ;
			endcase
		end
	end

	always_comb begin
		a_side.e   = 64'(enthalpy);
		a_side.wc  = water_change;
		a_side.sc  = solid_change;
		a_side.dep = layer_depth;
		a_num[0]   = 64'(water_ice_content);
		a_num[1]   = 64'(solid_content);
		a_den[0]   = 64'(layer_depth);
		a_den[1]   = 64'(layer_depth);
	end

	semsu_div #(.FRAC_BITS(FRAC_BITS), .LANES(2), .SIDE_W($bits(base_t))) u_div_rel (
		.clk(clk), .arst_n(arst_n), .en(en), .in_valid(in_valid),
		.num(a_num), .den(a_den), .in_side(a_side),
		.out_valid(a_vld), .quo(qa), .sat(sata), .zero(zeroa), .out_side(a_side_o)
	);

	always_comb begin
		b_side.base    = base_t'(a_side_o);
		b_side.rw      = qa[0];
		b_side.rs      = qa[1];
		b_side.fl.sat  = sata[0] | sata[1];
		b_side.fl.zero = zeroa[0] | zeroa[1];
		b_a[0] = qa[0];
		b_b[0] = 64'(lh_q);
		b_a[1] = 64'(ratio_w_q);
		b_b[1] = qa[1];
		b_a[2] = 64'(ratio_i_q);
		b_b[2] = qa[1];
	end

	semsu_mul #(.FRAC_BITS(FRAC_BITS), .LANES(3), .SIDE_W($bits(b_side_t))) u_mul_den (
		.clk(clk), .arst_n(arst_n), .en(en), .in_valid(a_vld),
		.a(b_a), .b(b_b), .in_side(b_side),
		.out_valid(b_vld), .p(pb), .sat(satb), .out_side(b_side_o)
	);

	// branch pick; a ratio product counts toward status only in its own thaw or freeze branch
	always_comb begin
		b_sd     = b_side_t'(b_side_o);
		b_thaw   = (b_sd.base.e >= pb[0]);
		b_frozen = !b_thaw && (b_sd.base.e <= 64'sd0);
		b_den    = iadd(b_sd.rw, b_thaw ? pb[1] : pb[2]);
		c_next.base    = b_sd.base;
		c_next.rw      = b_sd.rw;
		c_next.rs      = b_sd.rs;
		c_next.fl.zero = b_sd.fl.zero;
		c_next.fl.sat  = b_sd.fl.sat | satb[0]
			| (b_thaw & (satb[1] | b_den.sat))
			| (b_frozen & (satb[2] | b_den.sat));
		if (b_thaw) c_next.br = BR_THAW;
		else if (b_frozen) c_next.br = BR_FREEZE;
		else c_next.br = BR_PHASE;
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			c_vld_s3 <= 1'b0;
			d_vld_s5 <= 1'b0;
			e_vld_s7 <= 1'b0;
			out_valid <= 1'b0;
		end else if (en) begin
			c_vld_s3 <= b_vld;
			d_vld_s5 <= c_vld;
			e_vld_s7 <= d_vld;
			out_valid <= g_vld;
		end
	end

	always_ff @(posedge clk) begin
		if (en) begin
			c_side_s3   <= c_next;
			c_num_s3[0] <= b_thaw ? b_sd.base.e - pb[0] : b_sd.base.e;
			c_den_s3[0] <= b_den.val;
		end
	end

	semsu_div #(.FRAC_BITS(FRAC_BITS), .LANES(1), .SIDE_W($bits(c_side_t))) u_div_water (
		.clk(clk), .arst_n(arst_n), .en(en), .in_valid(c_vld_s3),
		.num(c_num_s3), .den(c_den_s3), .in_side(c_side_s3),
		.out_valid(c_vld), .quo(qc), .sat(satc), .zero(zeroc), .out_side(c_side_o)
	);

	always_comb begin
		c_sd = c_side_t'(c_side_o);
		c_lh = iadd(qc[0], 64'(lh_q));
		d_next.base = c_sd.base;
		d_next.rs   = c_sd.rs;
		d_next.fl   = c_sd.fl;
		unique case (c_sd.br)
			BR_THAW: begin
				d_next.ew      = c_lh.val;
				d_next.fl.sat  = c_sd.fl.sat | satc[0] | c_lh.sat;
				d_next.fl.zero = c_sd.fl.zero | zeroc[0];
			end
			BR_FREEZE: begin
				d_next.ew      = qc[0];
				d_next.fl.sat  = c_sd.fl.sat | satc[0];
				d_next.fl.zero = c_sd.fl.zero | zeroc[0];
			end
			default: begin
				// phase change keeps the enthalpy as water energy
				d_next.ew = c_sd.base.e;
			end
		endcase
	end

	always_ff @(posedge clk) begin
		if (en) begin
			d_side_s5 <= d_next;
			d_a_s5[0] <= d_next.ew;
			d_b_s5[0] <= c_sd.rw;
		end
	end

	semsu_mul #(.FRAC_BITS(FRAC_BITS), .LANES(1), .SIDE_W($bits(d_side_t))) u_mul_ewrw (
		.clk(clk), .arst_n(arst_n), .en(en), .in_valid(d_vld_s5),
		.a(d_a_s5), .b(d_b_s5), .in_side(d_side_s5),
		.out_valid(d_vld), .p(pd), .sat(satd), .out_side(d_side_o)
	);

	always_comb begin
		d_sd = d_side_t'(d_side_o);
		d_t  = iadd(d_sd.base.e, -pd[0]);
		e_next.base    = d_sd.base;
		e_next.ew      = d_sd.ew;
		e_next.fl.zero = d_sd.fl.zero;
		e_next.fl.sat  = d_sd.fl.sat | satd[0] | d_t.sat;
	end

	always_ff @(posedge clk) begin
		if (en) begin
			e_side_s7   <= e_next;
			e_num_s7[0] <= d_t.val;
			e_den_s7[0] <= d_sd.rs;
		end
	end

	semsu_div #(.FRAC_BITS(FRAC_BITS), .LANES(1), .SIDE_W($bits(e_side_t))) u_div_solid (
		.clk(clk), .arst_n(arst_n), .en(en), .in_valid(e_vld_s7),
		.num(e_num_s7), .den(e_den_s7), .in_side(e_side_s7),
		.out_valid(e_vld), .quo(qe), .sat(sate), .zero(zeroe), .out_side(e_side_o)
	);

	always_comb begin
		e_sd = e_side_t'(e_side_o);
		f_side.e       = e_sd.base.e;
		f_side.dep     = e_sd.base.dep;
		f_side.fl.sat  = e_sd.fl.sat | sate[0];
		f_side.fl.zero = e_sd.fl.zero | zeroe[0];
		f_a[0] = e_sd.ew;
		f_b[0] = 64'(e_sd.base.wc);
		f_a[1] = qe[0];
		f_b[1] = 64'(e_sd.base.sc);
	end

	semsu_mul #(.FRAC_BITS(FRAC_BITS), .LANES(2), .SIDE_W($bits(f_side_t))) u_mul_shift (
		.clk(clk), .arst_n(arst_n), .en(en), .in_valid(e_vld),
		.a(f_a), .b(f_b), .in_side(f_side),
		.out_valid(f_vld), .p(pf), .sat(satf), .out_side(f_side_o)
	);

	always_comb begin
		f_sd = f_side_t'(f_side_o);
		g_side.e       = f_sd.e;
		g_side.fl.sat  = f_sd.fl.sat | satf[0] | satf[1];
		g_side.fl.zero = f_sd.fl.zero;
		g_den[0] = 64'(f_sd.dep);
		g_den[1] = 64'(f_sd.dep);
	end

	semsu_div #(.FRAC_BITS(FRAC_BITS), .LANES(2), .SIDE_W($bits(g_side_t))) u_div_depth (
		.clk(clk), .arst_n(arst_n), .en(en), .in_valid(f_vld),
		.num(pf), .den(g_den), .in_side(g_side),
		.out_valid(g_vld), .quo(qg), .sat(satg), .zero(zerog), .out_side(g_side_o)
	);

	always_comb begin
		g_sd = g_side_t'(g_side_o);
		tot  = 66'(g_sd.e) + 66'(qg[0]) + 66'(qg[1]);
		if (tot > EMAX) begin
			res     = EMAX;
			res_sat = 1'b1;
		end else if (tot < EMIN) begin
			res     = EMIN;
			res_sat = 1'b1;
		end else begin
			res     = tot;
			res_sat = 1'b0;
		end
		fin.sat  = g_sd.fl.sat | satg[0] | satg[1] | res_sat;
		fin.zero = g_sd.fl.zero | zerog[0] | zerog[1];
	end

	always_ff @(posedge clk) begin
		if (en) begin
			new_enthalpy <= res[ENTH_WIDTH-1:0];
			if (fin.sat) status <= ST_SAT;
			else if (fin.zero) status <= ST_ZERO;
			else status <= ST_OK;
		end
	end

	`SEMSU_ASSERT_IMP(a_stall_only_when_full, clk, arst_n, !in_ready, out_valid && !out_ready, "input stalled while output register free")
endmodule
